/* rtl/core/sacl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;

	localparam int unsigned ADDR_PORT_W = 25;
	localparam int unsigned BURST_W     = 3;
	localparam int unsigned WAY_OUT_W   = 3;
	localparam int unsigned CNT_W       = 32;

	typedef struct packed {
		logic                 was_hit;
		logic [WAY_OUT_W-1:0] way;
		logic [CNT_W-1:0]     hit_total;
		logic [CNT_W-1:0]     miss_total;
	} sacl_res_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK
	} sacl_bk_state_t;

endpackage
`default_nettype wire

/* rtl/core/set_assoc_cache_lru_lookup.sv */
// a beat passes the front queue, the registered set read and the output queue before it can be popped
// a new access is taken only after the set row of the last one is written back and the output queue has room
// the tag, valid and recency memories have one port pair, so each access reads its set row, then writes it back
// reset: counters cleared; a clearing pass over all 2^floor(log2(SETS)) set rows (256 by default)
// sweeps the set memories, during which up to two beats are taken but none is returned
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_lookup #(
	parameter int unsigned SETS             = 256,
	parameter int unsigned WAYS             = 8,
	parameter int unsigned LINE_OFFSET_BITS = 4,
	parameter int unsigned ADDR_BITS        = 25
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [sacl_pkg::ADDR_PORT_W-1:0] byte_address,
	input  wire logic [sacl_pkg::BURST_W-1:0]     burst_length,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  was_hit,
	output logic [sacl_pkg::WAY_OUT_W-1:0]        way_used,
	output logic [sacl_pkg::CNT_W-1:0]            hit_total,
	output logic [sacl_pkg::CNT_W-1:0]            miss_total
);
	import sacl_pkg::*;

	localparam int unsigned SB      = $clog2(SETS + 1) - 1;
	localparam int unsigned AW      = (ADDR_BITS < ADDR_PORT_W) ? ADDR_BITS : ADDR_PORT_W;
	localparam int          TAG_RAW = int'(AW) - int'(LINE_OFFSET_BITS) - int'(SB);
	localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;

	logic               req_valid;
	logic               req_take;
	logic [SB-1:0]      req_set;
	logic [TAG_W-1:0]   req_tag;
	logic [BURST_W-1:0] req_burst;
	logic               out_room;
	logic               out_wr;
	sacl_res_t          out_res;
	sacl_res_t          head;

	sacl_front #(
		.LOB   (LINE_OFFSET_BITS),
		.SB    (SB),
		.TAG_W (TAG_W),
		.AW    (AW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_address (byte_address),
		.burst_length (burst_length),
		.push         (push),
		.full         (full),
		.req_valid    (req_valid),
		.req_take     (req_take),
		.req_set      (req_set),
		.req_tag      (req_tag),
		.req_burst    (req_burst)
	);

	sacl_back #(
		.WAYS  (WAYS),
		.SB    (SB),
		.TAG_W (TAG_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_take  (req_take),
		.req_set   (req_set),
		.req_tag   (req_tag),
		.req_burst (req_burst),
		.out_room  (out_room),
		.out_wr    (out_wr),
		.out_res   (out_res)
	);

	sacl_out_q u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wr_res (out_res),
		.room   (out_room),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign was_hit    = head.was_hit;
	assign way_used   = head.way;
	assign hit_total  = head.hit_total;
	assign miss_total = head.miss_total;
endmodule
`default_nettype wire

/* rtl/core/sacl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module sacl_front #(
	parameter int unsigned LOB   = 4,
	parameter int unsigned SB    = 8,
	parameter int unsigned TAG_W = 13,
	parameter int unsigned AW    = 25
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [sacl_pkg::ADDR_PORT_W-1:0] byte_address,
	input  wire logic [sacl_pkg::BURST_W-1:0]     burst_length,
	input  wire logic                             push,
	output logic                                  full,
	output logic                                  req_valid,
	input  wire logic                             req_take,
	output logic [SB-1:0]                         req_set,
	output logic [TAG_W-1:0]                      req_tag,
	output logic [sacl_pkg::BURST_W-1:0]          req_burst
);
	import sacl_pkg::*;

	localparam int unsigned EXT_W = ADDR_PORT_W + LOB + SB + TAG_W;

	logic [EXT_W-1:0]   a_ext;
	logic [SB-1:0]      set_q   [2];
	logic [TAG_W-1:0]   tag_q   [2];
	logic [BURST_W-1:0] burst_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic               wr_en;
	logic               rd_en;

	assign a_ext = EXT_W'(byte_address) & ~({EXT_W{1'b1}} << AW);

	assign full      = (cnt_q == 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = req_take && req_valid;
	assign req_set   = set_q[rp_q];
	assign req_tag   = tag_q[rp_q];
	assign req_burst = burst_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			set_q[wp_q]   <= a_ext[LOB +: SB];
			tag_q[wp_q]   <= a_ext[LOB + SB +: TAG_W];
			burst_q[wp_q] <= burst_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule
`default_nettype wire

/* rtl/core/sacl_out_q.sv */
`timescale 1ns / 1ps
`default_nettype none
module sacl_out_q (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr,
	input  wire sacl_pkg::sacl_res_t wr_res,
	output logic                     room,
	output logic                     empty,
	input  wire logic                pop,
	output sacl_pkg::sacl_res_t      head
);
	import sacl_pkg::*;

	sacl_res_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       rd_en;

	assign room  = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_en = pop && !empty;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd_en);
		end
	end
endmodule
`default_nettype wire

/* rtl/core/sacl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module sacl_back #(
	parameter int unsigned WAYS  = 8,
	parameter int unsigned SB    = 8,
	parameter int unsigned TAG_W = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_take,
	input  wire logic [SB-1:0]                req_set,
	input  wire logic [TAG_W-1:0]             req_tag,
	input  wire logic [sacl_pkg::BURST_W-1:0] req_burst,
	input  wire logic                         out_room,
	output logic                              out_wr,
	output sacl_pkg::sacl_res_t               out_res
);
	import sacl_pkg::*;

	localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ROWS  = 1 << SB;

	logic [WAYS-1:0]       vmem [ROWS];
	logic [WAYS*TAG_W-1:0] tmem [ROWS];
	logic [WAYS*WAY_W-1:0] omem [ROWS];

	logic [WAYS-1:0]       rd_v_q;
	logic [WAYS*TAG_W-1:0] rd_t_q;
	logic [WAYS*WAY_W-1:0] rd_o_q;

	sacl_bk_state_t        state_q;
	sacl_bk_state_t        state_d;
	logic [SB-1:0]         clr_q;
	logic [SB-1:0]         set_q;
	logic [TAG_W-1:0]      tag_q;
	logic [BURST_W-1:0]    burst_q;
	logic [CNT_W-1:0]      hit_q;
	logic [CNT_W-1:0]      miss_q;

	logic                  mem_we;
	logic [SB-1:0]         wr_addr;
	logic [WAYS-1:0]       wr_v;
	logic [WAYS*TAG_W-1:0] wr_t;
	logic [WAYS*WAY_W-1:0] wr_o;
	logic [WAYS*WAY_W-1:0] init_o;

	logic                  hit;
	logic [WAY_W-1:0]      way;
	logic [WAYS*TAG_W-1:0] upd_t;
	logic [WAYS*WAY_W-1:0] upd_o;
	logic [WAYS-1:0]       upd_v;
	logic [CNT_W-1:0]      hit_nx;
	logic [CNT_W-1:0]      miss_nx;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			init_o[i*WAY_W +: WAY_W] = WAY_W'(i);
		end
	end

	// tag compare, victim choice and recency move
	always_comb begin
		logic [WAY_W-1:0] ord [WAYS];
		logic             inv_any;
		logic [WAY_W-1:0] inv_way;
		logic [WAY_W-1:0] pos;
		logic             found;
		logic [CNT_W:0]   hsum;
		logic [CNT_W:0]   msum;
		hit     = 1'b0;
		way     = '0;
		inv_any = 1'b0;
		inv_way = '0;
		for (int i = 0; i < WAYS; i++) begin
			ord[i] = rd_o_q[i*WAY_W +: WAY_W];
		end
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (rd_v_q[i] && rd_t_q[i*TAG_W +: TAG_W] == tag_q) begin
				hit = 1'b1;
				way = WAY_W'(i);
			end
			if (!rd_v_q[i]) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(i);
			end
		end
		if (!hit) begin
			way = inv_any ? inv_way : ord[WAYS-1];
		end
		pos   = WAY_W'(WAYS - 1);
		found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && ord[i] == way) begin
				pos   = WAY_W'(i);
				found = 1'b1;
			end
		end
		upd_o = rd_o_q;
		upd_o[0 +: WAY_W] = way;
		for (int i = 1; i < WAYS; i++) begin
			if (WAY_W'(i) <= pos) begin
				upd_o[i*WAY_W +: WAY_W] = ord[i-1];
			end
		end
		upd_t = rd_t_q;
		upd_t[way*TAG_W +: TAG_W] = tag_q;
		upd_v = rd_v_q;
		upd_v[way] = 1'b1;
		hsum = {1'b0, hit_q} + (CNT_W+1)'(burst_q) + 1'b1;
		msum = {1'b0, miss_q} + 1'b1;
		hit_nx  = hit ? (hsum[CNT_W] ? {CNT_W{1'b1}} : hsum[CNT_W-1:0]) : hit_q;
		miss_nx = hit ? miss_q : (msum[CNT_W] ? {CNT_W{1'b1}} : msum[CNT_W-1:0]);
	end

	always_comb begin
		state_d  = state_q;
		req_take = 1'b0;
		out_wr   = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = set_q;
		wr_v     = upd_v;
		wr_t     = upd_t;
		wr_o     = upd_o;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q;
				wr_v    = '0;
				wr_t    = '0;
				wr_o    = init_o;
				if (clr_q == {SB{1'b1}}) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (req_valid && out_room) begin
					req_take = 1'b1;
					state_d  = BK_LOOK;
				end
			end
			BK_LOOK: begin
				mem_we  = 1'b1;
				out_wr  = 1'b1;
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign out_res.was_hit    = hit;
	assign out_res.way        = WAY_OUT_W'(way);
	assign out_res.hit_total  = hit_nx;
	assign out_res.miss_total = miss_nx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[wr_addr] <= wr_v;
			tmem[wr_addr] <= wr_t;
			omem[wr_addr] <= wr_o;
		end
		rd_v_q <= vmem[req_set];
		rd_t_q <= tmem[req_set];
		rd_o_q <= omem[req_set];
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			set_q   <= req_set;
			tag_q   <= req_tag;
			burst_q <= req_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			hit_q   <= '0;
			miss_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_wr) begin
				hit_q  <= hit_nx;
				miss_q <= miss_nx;
			end
		end
	end
endmodule
`default_nettype wire

/* sim/set_assoc_cache_lru_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [24:0] byte_address,
	input  wire logic [2:0]  burst_length,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic        was_hit,
	input  wire logic [2:0]  way_used,
	input  wire logic [31:0] hit_total,
	input  wire logic [31:0] miss_total,
	output int               fail_count,
	output int               pending,
	output int               hit_beats,
	output int               miss_beats
);
	import sacl_pkg::*;

	localparam int NSETS = 256;
	localparam int NWAYS = 8;

	logic [13:0]     line_tag [NSETS][NWAYS];
	bit              line_valid [NSETS][NWAYS];
	logic [2:0]      lru_rank [NSETS][NWAYS];
	logic [31:0]     hits_so_far;
	logic [31:0]     misses_so_far;
	sacl_res_t       lookup_queue [$];

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] d);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, d};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic predict_lookup(input logic [24:0] addr, input logic [2:0] burst);
		int set_idx;
		int way;
		int p;
		bit hit;
		logic [13:0] tag;
		sacl_res_t r;
		set_idx = int'(addr[11:4]);
		tag = {1'b0, addr[24:12]};
		way = 0;
		hit = 0;
		for (int w = 0; w < NWAYS; w++)
			if (!hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
				hit = 1;
				way = w;
			end
		if (hit) begin
			hits_so_far = sat_sum(hits_so_far, 32'd1 + 32'(burst));
		end else begin
			bit found;
			found = 0;
			misses_so_far = sat_sum(misses_so_far, 32'd1);
			for (int w = 0; w < NWAYS; w++)
				if (!found && !line_valid[set_idx][w]) begin
					found = 1;
					way = w;
				end
			if (!found)
				way = int'(lru_rank[set_idx][NWAYS-1]);
			line_tag[set_idx][way] = tag;
			line_valid[set_idx][way] = 1;
		end
		p = NWAYS - 1;
		for (int i = NWAYS - 1; i >= 0; i--)
			if (int'(lru_rank[set_idx][i]) == way)
				p = i;
		for (int i = p; i > 0; i--)
			lru_rank[set_idx][i] = lru_rank[set_idx][i-1];
		lru_rank[set_idx][0] = way[2:0];
		r.was_hit = hit;
		r.way = way[2:0];
		r.hit_total = hits_so_far;
		r.miss_total = misses_so_far;
		lookup_queue.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NSETS; s++)
				for (int w = 0; w < NWAYS; w++) begin
					line_valid[s][w] = 0;
					line_tag[s][w] = '0;
					lru_rank[s][w] = w[2:0];
				end
			hits_so_far = '0;
			misses_so_far = '0;
			lookup_queue.delete();
			fail_count = 0;
			hit_beats = 0;
			miss_beats = 0;
		end else begin
			if (pop && !empty) begin
				if (lookup_queue.size() == 0) begin
					$display("%0t: unexpected result beat, got hit=%0d way=%0d h=%0d m=%0d",
						$time, was_hit, way_used, hit_total, miss_total);
					fail_count++;
				end else begin
					sacl_res_t e;
					e = lookup_queue.pop_front();
					if (e.was_hit) hit_beats++; else miss_beats++;
					if (was_hit !== e.was_hit) begin
						$display("%0t: was_hit expected %0d actual %0d", $time, e.was_hit, was_hit);
						fail_count++;
					end
					if (way_used !== e.way) begin
						$display("%0t: way_used expected %0d actual %0d", $time, e.way, way_used);
						fail_count++;
					end
					if (hit_total !== e.hit_total) begin
						$display("%0t: hit_total expected %0d actual %0d", $time,
							e.hit_total, hit_total);
						fail_count++;
					end
					if (miss_total !== e.miss_total) begin
						$display("%0t: miss_total expected %0d actual %0d", $time,
							e.miss_total, miss_total);
						fail_count++;
					end
				end
			end
			if (push && !full)
				predict_lookup(byte_address, burst_length);
		end
		pending = lookup_queue.size();
	end
endmodule
`default_nettype wire

/* sim/set_assoc_cache_lru_lookup_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_lookup_tb;
	import sacl_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [24:0] byte_address;
	logic [2:0]  burst_length;
	logic        empty;
	logic        pop;
	logic        was_hit;
	logic [2:0]  way_used;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	int          fail_count;
	int          pending;
	int          hit_beats;
	int          miss_beats;
	int          cycle_count;
	bit          hold_rx;

	set_assoc_cache_lru_lookup dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.byte_address(byte_address), .burst_length(burst_length),
		.empty(empty), .pop(pop), .was_hit(was_hit), .way_used(way_used),
		.hit_total(hit_total), .miss_total(miss_total)
	);

	set_assoc_cache_lru_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.byte_address(byte_address), .burst_length(burst_length),
		.empty(empty), .pop(pop), .was_hit(was_hit), .way_used(way_used),
		.hit_total(hit_total), .miss_total(miss_total),
		.fail_count(fail_count), .pending(pending),
		.hit_beats(hit_beats), .miss_beats(miss_beats)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one beat, then an optional idle gap
	task automatic send_access(input logic [24:0] addr, input logic [2:0] burst);
		int g;
		@(negedge clk);
		push <= 1;
		byte_address <= addr;
		burst_length <= burst;
		@(posedge clk);
		while (full) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			push <= 0;
			byte_address <= 25'($urandom);
			burst_length <= 3'($urandom);
			repeat (g - 1) @(negedge clk);
		end
	endtask

	function automatic logic [24:0] mk_addr(int tag, int set_idx);
		logic [24:0] a;
		a = 25'($urandom);
		a[24:12] = tag[12:0];
		a[11:4] = set_idx[7:0];
		return a;
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) pop <= 0;
			else if ($urandom_range(0, 99) < 8) pop <= 0;
			else if ($urandom_range(0, 99) < 2) begin
				pop <= 0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else pop <= 1;
		end
	end

	initial begin
		hold_rx = 0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_rx = 1;
		repeat (200) @(posedge clk);
		hold_rx = 0;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 200000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int hot_set;
		int base_tag;
		push = 0;
		byte_address = '0;
		burst_length = '0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, every burst value, fill and evict one set
		send_access(25'h0, 3'd1);
		send_access(25'h0, 3'd0);
		send_access(25'h1FF_FFFF, 3'd7);
		send_access(25'h1FF_FFFF, 3'd4);
		for (int b = 0; b < 8; b++) send_access(25'h000_0010, b[2:0]);
		for (int t = 0; t < 9; t++) send_access(mk_addr(t + 100, 5), 3'd1);
		send_access(mk_addr(101, 5), 3'd2);
		send_access(mk_addr(100, 5), 3'd3);
		// random: mostly reuse within a few hot sets, some noise
		for (int n = 0; n < 600; n++) begin
			int r;
			r = $urandom_range(0, 99);
			hot_set = $urandom_range(0, 3) * 37;
			base_tag = $urandom_range(0, 11);
			if (r < 75)
				send_access(mk_addr(base_tag + 8000, hot_set), 3'($urandom_range(1, 4)));
			else if (r < 85)
				send_access(mk_addr(base_tag + 8000, hot_set), 3'($urandom));
			else
				send_access(25'($urandom), 3'($urandom));
		end
		@(negedge clk);
		push <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d hits and %0d misses over hot sets, extremes and evictions",
			hit_beats, miss_beats);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
rtl/core/sacl_pkg.sv
rtl/core/sacl_front.sv
rtl/core/sacl_out_q.sv
rtl/core/sacl_back.sv
rtl/core/set_assoc_cache_lru_lookup.sv
sim/set_assoc_cache_lru_checker.sv
sim/set_assoc_cache_lru_lookup_tb.sv
